// ===== src/ethernet_ip_header_parser_core_assert.svh =====
// Assertion macros used by the parser controller.
`ifndef ETHERNET_IP_HEADER_PARSER_CORE_ASSERT_SVH
`define ETHERNET_IP_HEADER_PARSER_CORE_ASSERT_SVH

// Check a property on the rising clock, idle while reset is applied.
`define EIPHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on the rising clock, reset included.
`define EIPHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/eiphp_pkg.sv =====
// Types, codes and constants of the Ethernet/IP header parser.
package eiphp_pkg;

  localparam int unsigned MaxFrameLenDefault = 65535;

  localparam logic [63:0] FnvBasis  = 64'hcbf29ce484222325;
  localparam logic [15:0] EtIpv4    = 16'h0800;
  localparam logic [15:0] EtIpv6    = 16'h86DD;
  localparam logic [15:0] EtVlan    = 16'h8100;
  localparam logic [7:0]  PrIcmp    = 8'd1;
  localparam logic [7:0]  PrTcp     = 8'd6;
  localparam logic [7:0]  PrUdp     = 8'd17;
  localparam logic [7:0]  PrIcmpv6  = 8'd58;
  localparam logic [3:0]  HashBytes = 4'd13;

  localparam logic [1:0] LayerRunt = 2'd0;
  localparam logic [1:0] LayerEth  = 2'd1;
  localparam logic [1:0] LayerIpv4 = 2'd2;
  localparam logic [1:0] LayerIpv6 = 2'd3;

  localparam logic [2:0] KindNone   = 3'd0;
  localparam logic [2:0] KindTcp    = 3'd1;
  localparam logic [2:0] KindUdp    = 3'd2;
  localparam logic [2:0] KindIcmp   = 3'd3;
  localparam logic [2:0] KindIcmpv6 = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [63:0] capture_ts;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  layer;
    logic [2:0]  transport_kind;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_ipv4;
    logic [31:0] dest_ipv4;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [63:0] conn_hash;
    logic [15:0] payload_offset;
    logic [15:0] payload_len;
    logic [63:0] frame_timestamp;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_RX,
    ST_EVAL,
    ST_HASH,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic take_byte;
    logic eval;
    logic hash_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_hash;
    logic hash_last;
  } dp_status_t;

endpackage

// ===== src/ethernet_ip_header_parser_core.sv =====
// Top level of the Ethernet/IPv4/IPv6/L4 header parser.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | in_item_i   (in_item_t)
//  out     | output    | out_valid_o/out_ready_i| out_item_o  (out_item_t)
//
// One byte per cycle while a frame streams in; header fields are captured on the fly.
// At the last byte the frame is evaluated, hashed over 13 tuple bytes for IPv4 TCP/UDP,
// and the summary is then loaded into the output register once that register is free.
// Input stalls while the summary is built; a waiting result blocks only the next summary.
// Asynchronous active-low reset clears the byte count, timestamp and control state.
module ethernet_ip_header_parser_core
  import eiphp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MaxFrameLenDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  eiphp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last_byte),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  eiphp_datapath #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

// ===== src/eiphp_ctrl.sv =====
// Controller of the header parser: byte intake, evaluation, hash and result hand-off.
module eiphp_ctrl
  import eiphp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   slot_free;

  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RX:   if (in_fire && in_last_i) state_d = ST_EVAL;
      ST_EVAL: state_d = status_i.need_hash ? ST_HASH : ST_PUSH;
      ST_HASH: if (status_i.hash_last) state_d = ST_PUSH;
      ST_PUSH: if (slot_free) state_d = ST_RX;
      default: state_d = ST_RX;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o         = (state_q == ST_RX);
    cmd_o.take_byte    = in_fire;
    cmd_o.eval         = (state_q == ST_EVAL);
    cmd_o.hash_step    = (state_q == ST_HASH);
    cmd_o.load_out     = (state_q == ST_PUSH) && slot_free;
  end

  // Track the result held in the output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`include "ethernet_ip_header_parser_core_assert.svh"

  `EIPHP_ASSERT(a_no_overwrite, (cmd_o.load_out && out_valid_q) |-> out_ready_i, "result overwritten")
  `EIPHP_ASSERT(a_last_evals, (in_fire && in_last_i) |=> (state_q == ST_EVAL), "frame end not evaluated")
  `EIPHP_ASSERT(a_skip_hash, (state_q == ST_EVAL && !status_i.need_hash) |=> (state_q == ST_PUSH), "hash not skipped")

endmodule

// ===== src/eiphp_datapath.sv =====
// Datapath of the header parser: field capture, frame evaluation and the FNV-1a hash.
module eiphp_datapath
  import eiphp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MaxFrameLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_item_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output out_item_t  out_item_o
);

  localparam logic [15:0] MaxLen = MAX_FRAME_LEN[15:0];

  logic [15:0] count_q, count_d, len_q;
  logic [63:0] ts_q;
  logic [15:0] et0_q, et1_q;
  logic [7:0]  ver_q, p4_q, p6_q, doff_q;
  logic [31:0] sip_q, dip_q;
  logic [15:0] sp_q, dp_q;

  // Capture positions for the current byte
  logic [15:0] n, ip_off, rel, l4_rel, l4r, eff_et;
  logic        ip_hit, l4_hit, take;
  logic [7:0]  b;

  assign n      = count_q;
  assign b      = in_item_i.data_byte;
  assign take   = cmd_i.take_byte && (count_q < MaxLen);
  assign ip_off = (et0_q == EtVlan) ? 16'd18 : 16'd14;
  assign eff_et = (et0_q == EtVlan) ? et1_q : et0_q;
  assign rel    = n - ip_off;
  assign ip_hit = (n >= ip_off);
  assign l4_rel = (eff_et == EtIpv6) ? 16'd40 : {10'd0, ver_q[3:0], 2'b00};
  assign l4r    = rel - l4_rel;
  assign l4_hit = ip_hit && (rel >= l4_rel);

  // Count bytes, saturating at the frame limit
  always_comb begin
    count_d = count_q;
    if (take) count_d = count_q + 16'd1;
    if (cmd_i.take_byte && in_item_i.last_byte) count_d = 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 16'd0;
      ts_q    <= 64'd0;
    end else begin
      count_q <= count_d;
      if (cmd_i.take_byte && count_q == 16'd0) ts_q <= in_item_i.capture_ts;
    end
  end

  // Grab header fields as their bytes pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && in_item_i.last_byte) len_q <= take ? count_q + 16'd1 : count_q;
    if (take) begin
      if (n == 16'd12 || n == 16'd13) et0_q <= {et0_q[7:0], b};
      if (n == 16'd16 || n == 16'd17) et1_q <= {et1_q[7:0], b};
      if (ip_hit) begin
        if (rel == 16'd0) ver_q <= b;
        if (rel == 16'd6) p6_q <= b;
        if (rel == 16'd9) p4_q <= b;
        if (rel >= 16'd12 && rel <= 16'd15) sip_q <= {sip_q[23:0], b};
        if (rel >= 16'd16 && rel <= 16'd19) dip_q <= {dip_q[23:0], b};
      end
      if (l4_hit) begin
        if (l4r == 16'd0 || l4r == 16'd1) sp_q <= {sp_q[7:0], b};
        if (l4r == 16'd2 || l4r == 16'd3) dp_q <= {dp_q[7:0], b};
        if (l4r == 16'd12) doff_q <= b;
      end
    end
  end

  // Evaluate the frame from the captured fields
  logic        vlan, ok4, ok6, okt, runt;
  logic [15:0] et, off, rem, hl, off2, rem2, thl, offf;
  logic [1:0]  layer;
  logic [2:0]  kind;
  logic [7:0]  proto;
  logic        have_pay, need_hash;

  always_comb begin
    runt  = (len_q < 16'd14);
    vlan  = (et0_q == EtVlan) && (len_q >= 16'd18);
    et    = vlan ? et1_q : et0_q;
    off   = vlan ? 16'd18 : 16'd14;
    rem   = len_q - off;
    hl    = {10'd0, ver_q[3:0], 2'b00};
    ok4   = (et == EtIpv4) && (rem >= 16'd20) && (ver_q[7:4] == 4'd4) &&
            (hl >= 16'd20) && (hl <= rem);
    ok6   = (et == EtIpv6) && (rem >= 16'd40) && (ver_q[7:4] == 4'd6);
    off2  = ok6 ? off + 16'd40 : off + hl;
    rem2  = len_q - off2;
    thl   = {10'd0, doff_q[7:4], 2'b00};
    okt   = (rem2 >= 16'd20) && (thl >= 16'd20) && (thl <= rem2);
    proto = ok4 ? p4_q : (ok6 ? p6_q : 8'd0);
    layer = ok4 ? LayerIpv4 : (ok6 ? LayerIpv6 : LayerEth);
    kind  = KindNone;
    offf  = off2;
    if (ok4 || ok6) begin
      if (proto == PrTcp && okt) begin
        kind = KindTcp;
        offf = off2 + thl;
      end else if (proto == PrUdp && rem2 >= 16'd8) begin
        kind = KindUdp;
        offf = off2 + 16'd8;
      end else if (ok4 && proto == PrIcmp && rem2 >= 16'd8) begin
        kind = KindIcmp;
        offf = off2 + 16'd8;
      end else if (ok6 && proto == PrIcmpv6 && rem2 >= 16'd8) begin
        kind = KindIcmpv6;
        offf = off2 + 16'd8;
      end
    end
    have_pay  = ok6 || (ok4 && kind != KindNone);
    need_hash = !runt && ok4 && (kind == KindTcp || kind == KindUdp);
    if (runt) begin
      layer = LayerRunt;
      kind  = KindNone;
      et    = 16'd0;
      proto = 8'd0;
    end
  end

  // Hold the evaluated summary
  out_item_t   ev_q;
  logic [63:0] h_q;
  logic [103:0] hv_q;
  logic [3:0]  hcnt_q;
  logic        hen_q;

  logic        swap;
  logic [31:0] a1, a2;
  logic [15:0] p1, p2;

  assign swap = !((sip_q < dip_q) || (sip_q == dip_q && sp_q < dp_q));
  assign a1   = swap ? dip_q : sip_q;
  assign a2   = swap ? sip_q : dip_q;
  assign p1   = swap ? dp_q : sp_q;
  assign p2   = swap ? sp_q : dp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      ev_q.layer           <= layer;
      ev_q.transport_kind  <= kind;
      ev_q.ether_type      <= et;
      ev_q.ip_protocol     <= proto;
      ev_q.source_ipv4     <= (!runt && ok4) ? sip_q : 32'd0;
      ev_q.dest_ipv4       <= (!runt && ok4) ? dip_q : 32'd0;
      ev_q.source_port     <= (kind == KindTcp || kind == KindUdp) ? sp_q : 16'd0;
      ev_q.dest_port       <= (kind == KindTcp || kind == KindUdp) ? dp_q : 16'd0;
      ev_q.conn_hash       <= 64'd0;
      ev_q.payload_offset  <= (!runt && have_pay && offf < len_q) ? offf : 16'd0;
      ev_q.payload_len     <= (!runt && have_pay && offf < len_q) ? len_q - offf : 16'd0;
      ev_q.frame_timestamp <= ts_q;
      hen_q                <= need_hash;
    end
  end

  // Run the hash one byte per cycle, least significant byte first
  logic [63:0] hx, hmul;
  assign hx   = h_q ^ {56'd0, hv_q[7:0]};
  assign hmul = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4) + (hx << 1) + hx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= 4'd0;
    end else if (cmd_i.eval) begin
      hcnt_q <= 4'd0;
    end else if (cmd_i.hash_step) begin
      hcnt_q <= hcnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      h_q  <= FnvBasis;
      hv_q <= {proto, p2[15:8], p2[7:0], p1[15:8], p1[7:0], a2, a1};
    end else if (cmd_i.hash_step) begin
      h_q  <= hmul;
      hv_q <= {8'd0, hv_q[103:8]};
    end
  end

  assign status_o.need_hash = need_hash;
  assign status_o.hash_last = (hcnt_q == HashBytes - 4'd1);

  // Merge the hash into the summary
  out_item_t load_item;
  always_comb begin
    load_item           = ev_q;
    load_item.conn_hash = hen_q ? h_q : 64'd0;
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_item_o <= load_item;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the Ethernet/IP header parser: random frames, predicted summaries.
`timescale 1ns / 1ps

module testbench;
  import eiphp_pkg::*;

  localparam int unsigned FrameLenMax = 65535;
  localparam int unsigned StoreBytes = 256;
  localparam logic [63:0] FnvPrime = 64'h100000001b3;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TargetBytes = 1150;

  // Header damage and timestamp choices of the frame builder
  localparam int BadNone = 0;
  localparam int BadIp = 1;
  localparam int BadL4 = 2;
  localparam int TsRand = 0;
  localparam int TsZero = 1;
  localparam int TsOnes = 2;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  ethernet_ip_header_parser_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  in_item_t    pending_bytes[$];
  out_item_t   frame_summaries[$];
  logic [7:0]  hdr_copy[StoreBytes];
  int unsigned frame_len;
  logic [63:0] frame_ts;
  int unsigned errors;
  int unsigned results_seen;
  int unsigned idle_cycles;

  // Clock and reset
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Header byte lookup, zero past the stored part
  function automatic logic [7:0] hb(int unsigned i);
    return (i < StoreBytes) ? hdr_copy[i] : 8'h00;
  endfunction

  function automatic logic [15:0] be16(int unsigned i);
    return {hb(i), hb(i + 1)};
  endfunction

  function automatic logic [31:0] be32(int unsigned i);
    return {be16(i), be16(i + 2)};
  endfunction

  // Symmetric FNV-1a over the 5-tuple, low byte first
  function automatic logic [63:0] tuple_hash(logic [31:0] sip, logic [31:0] dip,
                                             logic [15:0] sp, logic [15:0] dp,
                                             logic [7:0] pr);
    logic [63:0] h;
    logic [103:0] seq;
    h = FnvBasis;
    if (sip < dip || (sip == dip && sp < dp)) seq = {pr, dp, sp, dip, sip};
    else seq = {pr, sp, dp, sip, dip};
    for (int k = 0; k < 13; k++) begin
      h = (h ^ {56'd0, seq[8*k +: 8]}) * FnvPrime;
    end
    return h;
  endfunction

  // Parse TCP, UDP or the ICMP flavor at off; advance off on success
  function automatic bit parse_transport(inout out_item_t r, inout int unsigned off,
                                         input int unsigned len, input logic [7:0] icmp_pr,
                                         input logic [2:0] icmp_kind);
    int unsigned rem;
    int unsigned hl;
    logic [7:0] t;
    rem = len - off;
    if (r.ip_protocol == PrTcp) begin
      t = hb(off + 12);
      hl = t[7:4] * 4;
      if (rem >= 20 && hl >= 20 && hl <= rem) begin
        r.transport_kind = KindTcp;
        r.source_port = be16(off);
        r.dest_port = be16(off + 2);
        off += hl;
        return 1'b1;
      end
    end else if (r.ip_protocol == PrUdp) begin
      if (rem >= 8) begin
        r.transport_kind = KindUdp;
        r.source_port = be16(off);
        r.dest_port = be16(off + 2);
        off += 8;
        return 1'b1;
      end
    end else if (r.ip_protocol == icmp_pr) begin
      if (rem >= 8) begin
        r.transport_kind = icmp_kind;
        off += 8;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Build the summary of the frame held in hdr_copy
  function automatic out_item_t summarize_frame(int unsigned len);
    out_item_t r;
    int unsigned off;
    int unsigned rem;
    int unsigned hl;
    logic [15:0] et;
    logic [7:0] v;
    bit pay;
    r = '0;
    r.frame_timestamp = frame_ts;
    pay = 1'b0;
    if (len < 14) return r;
    r.layer = LayerEth;
    off = 14;
    et = be16(12);
    if (et == EtVlan && len >= 18) begin
      et = be16(16);
      off = 18;
    end
    rem = len - off;
    r.ether_type = et;
    if (et == EtIpv4) begin
      v = hb(off);
      hl = v[3:0] * 4;
      if (rem >= 20 && v[7:4] == 4'd4 && hl >= 20 && hl <= rem) begin
        r.layer = LayerIpv4;
        r.ip_protocol = hb(off + 9);
        r.source_ipv4 = be32(off + 12);
        r.dest_ipv4 = be32(off + 16);
        off += hl;
        pay = parse_transport(r, off, len, PrIcmp, KindIcmp);
        if (r.transport_kind == KindTcp || r.transport_kind == KindUdp) begin
          r.conn_hash = tuple_hash(r.source_ipv4, r.dest_ipv4, r.source_port,
                                   r.dest_port, r.ip_protocol);
        end
      end
    end else if (et == EtIpv6) begin
      v = hb(off);
      if (rem >= 40 && v[7:4] == 4'd6) begin
        r.layer = LayerIpv6;
        r.ip_protocol = hb(off + 6);
        off += 40;
        void'(parse_transport(r, off, len, PrIcmpv6, KindIcmpv6));
        pay = 1'b1;
      end
    end
    if (pay && off < len) begin
      r.payload_offset = 16'(off);
      r.payload_len = 16'(len - off);
    end
    return r;
  endfunction

  // Track one accepted byte; queue a summary at the frame end
  function automatic void track_byte(in_item_t it);
    if (frame_len == 0) frame_ts = it.capture_ts;
    if (frame_len < FrameLenMax) begin
      if (frame_len < StoreBytes) hdr_copy[frame_len] = it.data_byte;
      frame_len++;
    end
    if (it.last_byte) begin
      frame_summaries.push_back(summarize_frame(frame_len));
      frame_len = 0;
    end
  endfunction

  // Queue the bytes of one frame
  task automatic queue_frame(ref logic [7:0] f[$], input int tsm);
    in_item_t it;
    foreach (f[i]) begin
      it.data_byte = f[i];
      it.last_byte = (i == f.size() - 1);
      case (tsm)
        TsZero:  it.capture_ts = '0;
        TsOnes:  it.capture_ts = '1;
        default: it.capture_ts = {$urandom, $urandom};
      endcase
      pending_bytes.push_back(it);
    end
  endtask

  // Frame of fixed or random filler
  task automatic add_raw(int len, int val, int tsm);
    logic [7:0] f[$];
    for (int i = 0; i < len; i++) f.push_back((val < 0) ? 8'($urandom) : 8'(val));
    queue_frame(f, tsm);
  endtask

  // Frame with Ethernet, optional tag, IP and transport headers
  task automatic add_frame(bit vlan, logic [15:0] et, logic [7:0] pr, int bad, int pay,
                           int cut, int tsm);
    logic [7:0] f[$];
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
    int unsigned ihl;
    int unsigned doff;
    for (int i = 0; i < 12; i++) f.push_back(8'($urandom));
    if (vlan) begin
      f.push_back(EtVlan[15:8]);
      f.push_back(EtVlan[7:0]);
      f.push_back(8'($urandom));
      f.push_back(8'($urandom));
    end
    f.push_back(et[15:8]);
    f.push_back(et[7:0]);
    sip = $urandom;
    dip = ($urandom_range(0, 3) == 0) ? sip : $urandom;
    sp = 16'($urandom);
    dp = ($urandom_range(0, 3) == 0) ? sp : 16'($urandom);
    if (et == EtIpv4) begin
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 8) : 5;
      if (bad == BadIp && $urandom_range(0, 1)) f.push_back({4'($urandom_range(5, 15)), 4'(ihl)});
      else if (bad == BadIp) f.push_back({4'd4, 4'($urandom_range(0, 4))});
      else f.push_back({4'd4, 4'(ihl)});
      for (int i = 1; i < 9; i++) f.push_back(8'($urandom));
      f.push_back(pr);
      f.push_back(8'($urandom));
      f.push_back(8'($urandom));
      for (int i = 3; i >= 0; i--) f.push_back(sip[8*i +: 8]);
      for (int i = 3; i >= 0; i--) f.push_back(dip[8*i +: 8]);
      for (int i = 20; i < 4 * ihl; i++) f.push_back(8'($urandom));
    end else if (et == EtIpv6) begin
      if (bad == BadIp) f.push_back({4'($urandom_range(0, 5)), 4'($urandom)});
      else f.push_back({4'd6, 4'($urandom)});
      for (int i = 1; i < 6; i++) f.push_back(8'($urandom));
      f.push_back(pr);
      for (int i = 7; i < 40; i++) f.push_back(8'($urandom));
    end
    if (et == EtIpv4 || et == EtIpv6) begin
      f.push_back(sp[15:8]);
      f.push_back(sp[7:0]);
      f.push_back(dp[15:8]);
      f.push_back(dp[7:0]);
      if (pr == PrTcp) begin
        doff = (bad == BadL4) ? $urandom_range(0, 4) : $urandom_range(5, 8);
        for (int i = 4; i < 12; i++) f.push_back(8'($urandom));
        f.push_back({4'(doff), 4'($urandom)});
        for (int i = 13; i < ((doff < 5) ? 20 : 4 * doff); i++) f.push_back(8'($urandom));
      end else begin
        for (int i = 4; i < 8; i++) f.push_back(8'($urandom));
      end
    end
    for (int i = 0; i < pay; i++) f.push_back(8'($urandom));
    if (cut > 0 && cut < f.size()) f = f[0:cut-1];
    queue_frame(f, tsm);
  endtask

  // Sender: hold each item until taken, random idle gaps between items
  int unsigned send_gap;
  int unsigned send_calm;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
      send_gap <= 0;
      send_calm <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_item <= pending_bytes.pop_front();
        if (send_calm > 0) begin
          send_calm <= send_calm - 1;
          send_gap <= 0;
        end else begin
          if ($urandom_range(0, 40) == 0) send_calm <= 80;
          send_gap <= $urandom_range(0, 7);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off early in the run
  int unsigned recv_stall;
  int unsigned recv_calm;
  int unsigned recv_hold;
  bit          hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
      recv_calm <= 0;
      recv_hold <= 0;
      hold_done <= 1'b0;
    end else if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else if (out_valid && out_ready) begin
      if (!hold_done && results_seen >= 5) begin
        hold_done <= 1'b1;
        recv_hold <= HoldCycles;
        out_ready <= 1'b0;
      end else if (recv_calm > 0) begin
        recv_calm <= recv_calm - 1;
        out_ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 10) == 0) recv_calm <= 6;
        if ($urandom_range(0, 7) == 0) begin
          out_ready <= 1'b1;
        end else begin
          recv_stall <= $urandom_range(1, 7);
          out_ready <= 1'b0;
        end
      end
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_ready <= (recv_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check summaries, predict from accepted bytes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (frame_summaries.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected summary: %p", out_item);
        end else if (out_item !== frame_summaries[0]) begin
          errors++;
          if (errors <= 10) begin
            $display("summary mismatch\n  exp %p\n  got %p", frame_summaries[0], out_item);
          end
          void'(frame_summaries.pop_front());
        end else begin
          void'(frame_summaries.pop_front());
        end
      end
      if (in_valid && in_ready) track_byte(in_item);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[ethernet_ip_header_parser_core] ERROR");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int frames;
    int r;
    bit vl;
    logic [15:0] et;
    logic [7:0] pr;
    frame_len = 0;
    frame_ts = '0;
    errors = 0;
    results_seen = 0;
    idle_cycles = 0;
    foreach (hdr_copy[i]) hdr_copy[i] = '0;

    // Directed frames: runts, short tag, every protocol, broken headers, long frame
    add_raw(1, 0, TsZero);
    add_raw(13, 255, TsOnes);
    add_raw(14, 255, TsOnes);
    add_raw(16, 0, TsZero);
    add_frame(1'b1, EtIpv4, PrUdp, BadNone, 0, 17, TsRand);
    add_frame(1'b1, EtIpv4, PrUdp, BadNone, 4, 0, TsRand);
    add_frame(1'b0, EtIpv4, PrTcp, BadNone, 4, 0, TsRand);
    add_frame(1'b0, EtIpv4, PrUdp, BadNone, 2, 0, TsRand);
    add_frame(1'b0, EtIpv4, PrIcmp, BadNone, 2, 0, TsRand);
    add_frame(1'b0, EtIpv4, 8'd99, BadNone, 2, 0, TsRand);
    add_frame(1'b1, EtIpv6, PrTcp, BadNone, 2, 0, TsRand);
    add_frame(1'b0, EtIpv6, PrUdp, BadNone, 2, 0, TsRand);
    add_frame(1'b0, EtIpv6, PrIcmpv6, BadNone, 2, 0, TsRand);
    add_frame(1'b0, EtIpv6, 8'd99, BadNone, 1, 0, TsRand);
    add_frame(1'b0, EtIpv4, PrTcp, BadIp, 2, 0, TsRand);
    add_frame(1'b0, EtIpv6, PrUdp, BadIp, 2, 0, TsRand);
    add_frame(1'b0, EtIpv4, PrTcp, BadNone, 0, 30, TsRand);
    add_frame(1'b0, EtIpv4, PrTcp, BadL4, 2, 0, TsRand);
    add_frame(1'b0, EtIpv6, PrTcp, BadL4, 2, 0, TsRand);
    add_frame(1'b0, EtIpv6, PrUdp, BadNone, 0, 60, TsRand);
    add_frame(1'b0, EtIpv4, PrUdp, BadNone, 0, 0, TsRand);
    add_frame(1'b0, EtIpv6, PrTcp, BadNone, 0, 0, TsRand);
    add_frame(1'b0, 16'h1234, PrUdp, BadNone, 4, 0, TsRand);
    add_frame(1'b0, EtIpv4, PrTcp, BadNone, 120, 0, TsRand);

    // Random frames, mostly well formed
    frames = 0;
    while (pending_bytes.size() < TargetBytes) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        add_raw($urandom_range(1, 40), -1, TsRand);
      end else begin
        vl = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        et = (r < 45) ? EtIpv4 : (r < 80) ? EtIpv6 : (r < 85) ? EtVlan : 16'($urandom);
        r = $urandom_range(0, 99);
        pr = (r < 35) ? PrTcp : (r < 70) ? PrUdp : (r < 85) ? ((et == EtIpv6) ? PrIcmpv6 : PrIcmp)
             : 8'($urandom);
        r = $urandom_range(0, 99);
        add_frame(vl, et, pr, (r < 8) ? BadIp : (r < 16) ? BadL4 : BadNone,
                  ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40),
                  ($urandom_range(0, 6) == 0) ? $urandom_range(1, 90) : 0, TsRand);
      end
      frames++;
    end

    wait (rst_ni && pending_bytes.size() == 0 && !in_valid && frame_summaries.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && frame_summaries.size() == 0) begin
      $display("[ethernet_ip_header_parser_core] OK");
    end else begin
      $display("[ethernet_ip_header_parser_core] ERROR");
    end
    $finish;
  end

endmodule
